// ===== rtl/pcg_pkg.sv =====
// Shared types and constants of the per-channel gain normalisation block.
`timescale 1ns / 1ps

package pcg_pkg;

    // Gain table geometry
    localparam int TABLE_WORDS = 125;
    localparam int ADDR_W      = 7;
    localparam int WORD_W      = 16;
    localparam int FRAC_W      = 10;

    // Request actions
    localparam logic ACT_APPLY = 1'b0;
    localparam logic ACT_LOAD  = 1'b1;

    // One request as it arrives on the input channel
    typedef struct packed {
        logic                     action;
        logic [31:0]              energy;
        logic [31:0]              noise_level;
        logic                     last_channel;
        logic [ADDR_W-1:0]        table_index;
        logic signed [WORD_W-1:0] table_word;
    } pcg_in_t;

    // One result as it leaves on the output channel
    typedef struct packed {
        logic [25:0] normalized;
        logic        frame_end;
    } pcg_out_t;

    // Hand-over from the gain lookup to the scaling pipeline
    typedef struct packed {
        logic              valid;
        logic              last_channel;
        logic [31:0]       energy;
        logic [WORD_W-1:0] gain;
    } pcg_gain_t;

endpackage

// ===== rtl/pcg_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module pcg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 125
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/pcg_gain.sv =====
// Gain lookup: segment search, table read and piecewise quadratic evaluation.
`timescale 1ns / 1ps

module pcg_gain (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            item_valid,
    input  pcg_pkg::pcg_in_t item,
    output pcg_pkg::pcg_gain_t gain_out
);
    import pcg_pkg::*;

    // Stage 1: captured request
    logic    s1_valid_reg;
    pcg_in_t s1_item_reg;

    // Stage 2: bit length of the noise estimate
    logic                     s2_valid_reg;
    logic                     s2_action_reg;
    logic [5:0]               s2_len_reg;
    logic [31:0]              s2_noise_reg;
    logic [31:0]              s2_energy_reg;
    logic                     s2_last_reg;
    logic [ADDR_W-1:0]        s2_index_reg;
    logic [WORD_W-1:0]        s2_word_reg;

    // Stage 3: table addresses and fraction, table access
    logic                     s3_valid_reg;
    logic                     s3_action_reg;
    logic [ADDR_W-1:0]        s3_addr_reg [3];
    logic [FRAC_W-1:0]        s3_frac_reg;
    logic                     s3_small_reg;
    logic [31:0]              s3_energy_reg;
    logic                     s3_last_reg;
    logic [ADDR_W-1:0]        s3_index_reg;
    logic [WORD_W-1:0]        s3_word_reg;

    // Stage 4: table words available
    logic                     s4_valid_reg;
    logic [FRAC_W-1:0]        s4_frac_reg;
    logic                     s4_small_reg;
    logic [31:0]              s4_energy_reg;
    logic                     s4_last_reg;
    logic [WORD_W-1:0]        rd_word [3];

    // Stage 5: linear term done
    logic                     s5_valid_reg;
    logic signed [22:0]       s5_lin_reg;
    logic [FRAC_W-1:0]        s5_frac_reg;
    logic                     s5_small_reg;
    logic [WORD_W-1:0]        s5_t0_reg;
    logic [31:0]              s5_energy_reg;
    logic                     s5_last_reg;

    // Stage 6: finished gain
    logic                     s6_valid_reg;
    logic                     s6_last_reg;
    logic [31:0]              s6_energy_reg;
    logic [WORD_W-1:0]        s6_gain_reg;

    logic [5:0]               len_next;
    logic [4:0]               norm_sh;
    logic [31:0]              norm;
    logic [ADDR_W-1:0]        base;
    logic                     direct_hit;
    logic [ADDR_W-1:0]        addr_next [3];
    logic                     wr_en;
    logic signed [15:0]       t2;
    logic signed [10:0]       frac4;
    logic signed [26:0]       prod2;
    logic signed [22:0]       lin_next;
    logic signed [10:0]       frac5;
    logic signed [33:0]       prod1;
    logic [33:0]              rounded;
    logic [WORD_W-1:0]        gain_next;

    // Bit length: position of the leading one plus one
    always_comb
    begin
        len_next = 6'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (s1_item_reg.noise_level[i])
            begin
                len_next = 6'(i + 1);
            end
        end
    end

    // Fraction is the ten bits after the leading one; segment base is 4*len-6
    always_comb
    begin
        direct_hit   = (s2_noise_reg <= 32'd2);
        norm_sh      = 5'(6'd32 - s2_len_reg);
        norm         = s2_noise_reg << norm_sh;
        base         = direct_hit ? '0 : ADDR_W'({s2_len_reg, 2'b00} - 8'd6);
        addr_next[0] = direct_hit ? ADDR_W'(s2_noise_reg[1:0]) : base;
        addr_next[1] = base + ADDR_W'(1);
        addr_next[2] = base + ADDR_W'(2);
    end

    // Loads write all three table copies in request order
    assign wr_en = en && s3_valid_reg && (s3_action_reg == ACT_LOAD) &&
                   (s3_index_reg < ADDR_W'(TABLE_WORDS));

    // One copy of the table per coefficient so that all three read at once
    for (genvar k = 0; k < 3; k++)
    begin : g_copy
        pcg_ram #(
            .WIDTH (WORD_W),
            .DEPTH (TABLE_WORDS)
        ) u_ram (
            .clk     (clk),
            .wr_en   (wr_en),
            .wr_addr (s3_index_reg),
            .wr_data (s3_word_reg),
            .rd_en   (en),
            .rd_addr (s3_addr_reg[k]),
            .rd_data (rd_word[k])
        );
    end

    // Linear term: floor(t2*f/32) + t1*32
    always_comb
    begin
        t2       = rd_word[2];
        frac4    = {1'b0, s4_frac_reg};
        prod2    = t2 * frac4;
        lin_next = {prod2[26], prod2[26:5]} +
                   {{2{rd_word[1][WORD_W-1]}}, rd_word[1], 5'b00000};
    end

    // Quadratic term with rounding, truncated to the 16-bit gain
    always_comb
    begin
        frac5     = {1'b0, s5_frac_reg};
        prod1     = s5_lin_reg * frac5;
        rounded   = prod1 + 34'sd16384;
        gain_next = s5_small_reg ? s5_t0_reg : (rounded[30:15] + s5_t0_reg);
    end

    // Valid bits of every stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= item_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg && (s3_action_reg == ACT_APPLY);
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    // Payload of every stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_item_reg          <= item;

            s2_action_reg        <= s1_item_reg.action;
            s2_len_reg           <= len_next;
            s2_noise_reg         <= s1_item_reg.noise_level;
            s2_energy_reg        <= s1_item_reg.energy;
            s2_last_reg          <= s1_item_reg.last_channel;
            s2_index_reg         <= s1_item_reg.table_index;
            s2_word_reg          <= s1_item_reg.table_word;

            s3_action_reg        <= s2_action_reg;
            s3_addr_reg          <= addr_next;
            s3_frac_reg          <= norm[30:21];
            s3_small_reg         <= direct_hit;
            s3_energy_reg        <= s2_energy_reg;
            s3_last_reg          <= s2_last_reg;
            s3_index_reg         <= s2_index_reg;
            s3_word_reg          <= s2_word_reg;

            s4_frac_reg          <= s3_frac_reg;
            s4_small_reg         <= s3_small_reg;
            s4_energy_reg        <= s3_energy_reg;
            s4_last_reg          <= s3_last_reg;

            s5_lin_reg           <= lin_next;
            s5_frac_reg          <= s4_frac_reg;
            s5_small_reg         <= s4_small_reg;
            s5_t0_reg            <= rd_word[0];
            s5_energy_reg        <= s4_energy_reg;
            s5_last_reg          <= s4_last_reg;

            s6_last_reg          <= s5_last_reg;
            s6_energy_reg        <= s5_energy_reg;
            s6_gain_reg          <= gain_next;
        end
    end

    // Hand-over to the scaling pipeline
    always_comb
    begin
        gain_out.valid        = s6_valid_reg;
        gain_out.last_channel = s6_last_reg;
        gain_out.energy       = s6_energy_reg;
        gain_out.gain         = s6_gain_reg;
    end

endmodule

// ===== rtl/pcg_scale.sv =====
// Scaling: energy times gain, configured right shift and the shrink curve.
`timescale 1ns / 1ps

module pcg_scale #(
    parameter int SNR_BITS    = 12,
    parameter int OUTPUT_BITS = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  pcg_pkg::pcg_gain_t gain_in,
    input  logic [5:0]         prod_shift,
    output logic               result_valid,
    output pcg_pkg::pcg_out_t  result
);
    import pcg_pkg::*;

    localparam int          SQ_W     = 2 * SNR_BITS + 2;
    localparam int          SQ_SHIFT = 2 + 2 * SNR_BITS - OUTPUT_BITS;
    localparam int          LIN_SH   = SNR_BITS - OUTPUT_BITS;
    localparam logic [31:0] KNEE     = 32'(2) << SNR_BITS;
    localparam logic [31:0] OFFSET   = 32'(1) << OUTPUT_BITS;

    logic               p_valid_reg;
    logic               p_last_reg;
    logic [63:0]        p_prod_reg;

    logic               s_valid_reg;
    logic               s_last_reg;
    logic [31:0]        s_snr_reg;

    logic               o_valid_reg;
    pcg_out_t           o_result_reg;

    logic [31:0]        gain_ext;
    logic [SNR_BITS:0]  low_part;
    logic [SQ_W-1:0]    square;
    logic [31:0]        square32;
    logic [31:0]        shrunk;

    // Gain is sign-extended to 32 bits and then taken as unsigned
    assign gain_ext = {{(32 - WORD_W){gain_in.gain[WORD_W-1]}}, gain_in.gain};

    // Shrink: square below the knee, linear offset above it
    always_comb
    begin
        low_part = s_snr_reg[SNR_BITS:0];
        square   = SQ_W'(low_part) * SQ_W'(low_part);
        square32 = 32'(square);
        if (s_snr_reg < KNEE)
        begin
            shrunk = square32 >> SQ_SHIFT;
        end
        else
        begin
            shrunk = (s_snr_reg >> LIN_SH) - OFFSET;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= gain_in.valid;
            s_valid_reg <= p_valid_reg;
            o_valid_reg <= s_valid_reg;
        end
    end

    // Product, shift and output registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_prod_reg              <= gain_in.energy * gain_ext;
            p_last_reg              <= gain_in.last_channel;
            s_snr_reg               <= 32'(p_prod_reg >> prod_shift);
            s_last_reg              <= p_last_reg;
            o_result_reg.normalized <= shrunk[25:0];
            o_result_reg.frame_end  <= s_last_reg;
        end
    end

    assign result_valid = o_valid_reg;
    assign result       = o_result_reg;

endmodule

// ===== rtl/pcan_channel_gain_core.sv =====
// Top level of the per-channel energy normalisation gain block.
`timescale 1ns / 1ps
//
// Requests enter on item_valid / item_ready with an item struct. An apply
// request carries one channel's energy and noise estimate and yields one
// result on result_valid / result_ready; a load request writes one word of
// the 125-word gain table and yields none. Every table word must be loaded
// before an apply request reads it.
// The product shift register is written on cfg_valid / cfg_ready (always
// ready); the user must write it only while no request is in flight, which
// the block does not enforce. Results pass through nine register stages. One
// request is accepted every cycle unless the receiver stalls; the nine-stage
// pipeline with three table copies read in parallel sets that rate.
// Reset clears all valid bits and sets the product shift to zero; the table
// contents stay undefined until loaded.
// When the receiver stalls, the whole pipeline holds and item_ready falls
// in the same cycle; nothing is lost or repeated.
//
module pcan_channel_gain_core #(
    parameter int SNR_BITS    = 12,
    parameter int OUTPUT_BITS = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  pcg_pkg::pcg_in_t  item,
    output logic              result_valid,
    input  logic              result_ready,
    output pcg_pkg::pcg_out_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [5:0]        cfg_prod_shift
);
    import pcg_pkg::*;

    logic       en;
    logic [5:0] prod_shift_reg;
    pcg_gain_t  gain_link;

    // Pipeline advances whenever the output register is free or drained
    assign en         = !result_valid || result_ready;
    assign item_ready = en;
    assign cfg_ready  = 1'b1;

    // Shift configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_shift_reg <= 6'd0;
        end
        else if (cfg_valid)
        begin
            prod_shift_reg <= cfg_prod_shift;
        end
    end

    pcg_gain u_gain (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .item_valid (item_valid),
        .item       (item),
        .gain_out   (gain_link)
    );

    pcg_scale #(
        .SNR_BITS    (SNR_BITS),
        .OUTPUT_BITS (OUTPUT_BITS)
    ) u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .gain_in      (gain_link),
        .prod_shift   (prod_shift_reg),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== tb/sv/pcan_channel_gain_core_tb.sv =====
// Self-checking testbench of the per-channel energy normalisation gain block.
`timescale 1ns / 1ps

module pcan_channel_gain_core_tb;

    import pcg_pkg::*;

    localparam int SNR_BITS     = 12;
    localparam int OUTPUT_BITS  = 6;
    localparam int CLK_PERIOD   = 20;
    localparam int SETTLE_TICKS = 16;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_ready;
    pcg_in_t   item;
    logic      result_valid;
    logic      result_ready;
    pcg_out_t  result;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [5:0] cfg_prod_shift;

    // Shadow of the block state used for prediction
    logic signed [WORD_W-1:0] gain_words [0:TABLE_WORDS-1];
    logic [5:0]               shift_setting;

    // Results still owed by the block, oldest first
    pcg_out_t pending_results [$];
    int       mismatch_count;

    pcan_channel_gain_core #(
        .SNR_BITS    (SNR_BITS),
        .OUTPUT_BITS (OUTPUT_BITS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .item           (item),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result         (result),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_prod_shift (cfg_prod_shift)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Expected result of one apply request under the current table and shift.
    function automatic pcg_out_t normalise_channel(input pcg_in_t req);
        int unsigned blen;
        int unsigned seg;
        longint      frac;
        longint      acc;
        logic [15:0] gain;
        logic [31:0] gain_ext;
        logic [63:0] product;
        logic [31:0] snr;
        logic [31:0] square;
        pcg_out_t    res;
        if (req.noise_level <= 32'd2)
        begin
            gain = gain_words[req.noise_level[1:0]];
        end
        else
        begin
            blen = 0;
            for (int i = 0; i < 32; i++)
            begin
                if (req.noise_level[i])
                    blen = i + 1;
            end
            seg = 4 * blen - 6;
            // Ten bits after the leading one, left-aligned for short values.
            if (blen < 11)
                frac = longint'((req.noise_level << (11 - blen)) & 32'h3FF);
            else
                frac = longint'((req.noise_level >> (blen - 11)) & 32'h3FF);
            acc = ((longint'(gain_words[seg + 2]) * frac) >>> 5)
                  + longint'(gain_words[seg + 1]) * 32;
            acc = ((acc * frac + 16384) >>> 15) + longint'(gain_words[seg]);
            gain = acc[15:0];
        end
        gain_ext = {{16{gain[15]}}, gain};
        product  = {32'd0, req.energy} * {32'd0, gain_ext};
        snr      = 32'(product >> shift_setting);
        // Square below the knee, linear offset above it.
        if (snr < (32'd2 << SNR_BITS))
        begin
            square         = snr * snr;
            res.normalized = 26'(square >> (2 + 2 * SNR_BITS - OUTPUT_BITS));
        end
        else
        begin
            res.normalized = 26'((snr >> (SNR_BITS - OUTPUT_BITS))
                                 - (32'd1 << OUTPUT_BITS));
        end
        res.frame_end = req.last_channel;
        return res;
    endfunction

    // Apply request; the table fields carry noise since the block ignores them.
    function automatic pcg_in_t make_apply(input logic [31:0] energy,
                                           input logic [31:0] noise,
                                           input logic        last);
        pcg_in_t req;
        req.action       = ACT_APPLY;
        req.energy       = energy;
        req.noise_level  = noise;
        req.last_channel = last;
        req.table_index  = ADDR_W'($urandom);
        req.table_word   = WORD_W'($urandom);
        return req;
    endfunction

    // Load request; the channel fields carry noise since the block ignores them.
    function automatic pcg_in_t make_load(input logic [ADDR_W-1:0] index,
                                          input logic [WORD_W-1:0] word);
        pcg_in_t req;
        req.action       = ACT_LOAD;
        req.energy       = $urandom;
        req.noise_level  = $urandom;
        req.last_channel = 1'($urandom);
        req.table_index  = index;
        req.table_word   = word;
        return req;
    endfunction

    // Random value with a random bit length, so that every segment is reached.
    function automatic logic [31:0] spread_value();
        int unsigned blen;
        logic [31:0] v;
        blen = $urandom_range(0, 32);
        if (blen == 0)
            return 32'($urandom_range(0, 2));
        v = $urandom;
        if (blen < 32)
            v = v & ((32'd1 << blen) - 1);
        v[blen - 1] = 1'b1;
        return v;
    endfunction

    // Presents one request and waits for it to be taken, then updates the shadow.
    task automatic send_request(input pcg_in_t req);
        @(negedge clk);
        item_valid <= 1'b1;
        item       <= req;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        if (req.action == ACT_LOAD)
        begin
            if (req.table_index < TABLE_WORDS)
                gain_words[req.table_index] = req.table_word;
        end
        else
        begin
            pending_results.push_back(normalise_channel(req));
        end
    endtask

    task automatic idle_cycle();
        @(negedge clk);
        item_valid <= 1'b0;
    endtask

    // Waits until every result is in and any trailing loads have left the pipeline.
    task automatic drain_pipeline();
        int ready_ticks;
        idle_cycle();
        while (pending_results.size() != 0)
            @(posedge clk);
        ready_ticks = 0;
        while (ready_ticks < SETTLE_TICKS)
        begin
            @(posedge clk);
            if (result_ready)
                ready_ticks++;
        end
    endtask

    task automatic write_prod_shift(input logic [5:0] value);
        drain_pipeline();
        @(negedge clk);
        cfg_valid      <= 1'b1;
        cfg_prod_shift <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shift_setting = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Fills the whole table so that every later apply reads written words.
    task automatic load_gain_table();
        for (int i = 0; i < TABLE_WORDS; i++)
        begin
            if (i == 3)
                send_request(make_load(ADDR_W'(i), 16'sh8000));
            else if (i == 4)
                send_request(make_load(ADDR_W'(i), 16'sh7FFF));
            else
                send_request(make_load(ADDR_W'(i), WORD_W'($urandom)));
        end
    endtask

    // Direct lookups, segment boundaries and the widest noise values.
    task automatic check_noise_segments();
        logic [31:0] probes [13];
        probes = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd7, 32'd1023, 32'd1024,
                   32'd2047, 32'd2048, 32'h0001_2345, 32'h8000_0000, 32'hFFFF_FFFF};
        write_prod_shift(6'd16);
        foreach (probes[i])
            send_request(make_apply((i % 2) ? 32'hFFFF_FFFF : 32'h0001_0000,
                                    probes[i], 1'(i % 2)));
        send_request(make_apply(32'd0, 32'hFFFF_FFFF, 1'b1));
    endtask

    // Loads at the table ends, and beyond them, which must be dropped.
    task automatic check_table_edges();
        send_request(make_load(7'd125, 16'sh1234));
        send_request(make_load(7'd127, 16'shFFFF));
        send_request(make_load(7'd0, 16'sh8000));
        send_request(make_load(7'd124, 16'sh7FFF));
        send_request(make_apply(32'hFFFF_FFFF, 32'd0, 1'b0));
        send_request(make_apply(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    endtask

    // Largest and smallest shift of the product.
    task automatic check_shift_extremes();
        write_prod_shift(6'd63);
        send_request(make_apply(32'hFFFF_FFFF, 32'd1, 1'b0));
        send_request(make_apply(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        write_prod_shift(6'd0);
        send_request(make_apply(32'hFFFF_FFFF, 32'd2, 1'b0));
        send_request(make_apply(32'd1, 32'd5, 1'b1));
    endtask

    // Bursty random traffic over several shift settings.
    task automatic run_random_traffic(input int count);
        logic [5:0] shifts [8];
        int         burst_left;
        int         pick;
        shifts = '{6'd12, 6'd0, 6'd63, 6'($urandom), 6'd28, 6'd20,
                   6'($urandom), 6'd16};
        burst_left = 0;
        for (int n = 0; n < count; n++)
        begin
            if (n % (count / 8) == 0 && n / (count / 8) < 8)
                write_prod_shift(shifts[n / (count / 8)]);
            // Hold off once mid-phase until everything owed has come back.
            if (n == count / 3 + 17)
                drain_pipeline();
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 2) != 0)
                    repeat ($urandom_range(1, 8)) idle_cycle();
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            pick = $urandom_range(0, 99);
            if (pick < 88)
                send_request(make_apply(($urandom_range(0, 3) == 0) ? $urandom
                                                                    : spread_value(),
                                        spread_value(), ($urandom_range(0, 7) == 0)));
            else
                send_request(make_load(ADDR_W'($urandom_range(0, 127)), WORD_W'($urandom)));
        end
    endtask

    // Receiver stalls: always ready, random, periodic or mostly stalled, by phase.
    initial
    begin
        int mode;
        int span;
        int tick;
        tick = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0: result_ready <= 1'b1;
                    1: result_ready <= 1'($urandom);
                    2: result_ready <= (tick % 5) != 0;
                    default: result_ready <= $urandom_range(0, 9) > 6;
                endcase
                tick++;
            end
        end
    end

    // Compares each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        pcg_out_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none owed: normalized=%0d frame_end=%0b",
                         $time, result.normalized, result.frame_end);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.normalized !== want.normalized)
                begin
                    $display("%0t: normalized expected %0d, got %0d",
                             $time, want.normalized, result.normalized);
                    mismatch_count++;
                end
                if (result.frame_end !== want.frame_end)
                begin
                    $display("%0t: frame_end expected %0b, got %0b",
                             $time, want.frame_end, result.frame_end);
                    mismatch_count++;
                end
            end
        end
    end

    // Guard against a hung block.
    initial
    begin
        #10_000_000;
        $display("pcan_channel_gain_core: mismatch");
        $finish;
    end

    // Test sequence.
    initial
    begin
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        item           = '0;
        result_ready   = 1'b0;
        cfg_valid      = 1'b0;
        cfg_prod_shift = 6'd0;
        shift_setting  = 6'd0;
        mismatch_count = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        load_gain_table();
        check_noise_segments();
        check_table_edges();
        check_shift_extremes();
        run_random_traffic(550);

        drain_pipeline();
        if (mismatch_count == 0)
            $display("pcan_channel_gain_core: match");
        else
            $display("pcan_channel_gain_core: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pcg_pkg.sv
rtl/pcg_ram.sv
rtl/pcg_gain.sv
rtl/pcg_scale.sv
rtl/pcan_channel_gain_core.sv
tb/sv/pcan_channel_gain_core_tb.sv
